FILE: src/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduce unit.
package rar_pkg;

  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // which cross product the shared multiplier forms
  typedef enum logic [1:0] {
    MS_FIRST  = 2'd0,
    MS_SECOND = 2'd1,
    MS_THIRD  = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     en;
    mul_sel_t sel;
    op_t      op;
  } mul_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_M0     = 3'd1,
    ST_M1     = 3'd2,
    ST_M2     = 3'd3,
    ST_M3     = 3'd4,
    ST_CHECK  = 3'd5,
    ST_REDUCE = 3'd6,
    ST_OUT    = 3'd7
  } state_t;

  typedef enum logic [1:0] {
    RD_IDLE = 2'd0,
    RD_GCD  = 2'd1,
    RD_DIV  = 2'd2
  } red_state_t;

endpackage

FILE: src/rar_if.sv
// Request and response channel interfaces.
interface rar_req_if #(parameter int VALUE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [VALUE_BITS-1:0] a_num;
  logic signed [VALUE_BITS-1:0] a_den;
  logic signed [VALUE_BITS-1:0] b_num;
  logic signed [VALUE_BITS-1:0] b_den;

  modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rar_pkg::RES_NUM_W-1:0] res_num;
  logic [rar_pkg::RES_DEN_W-1:0]        res_den;
  logic                                 status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

FILE: src/rar_mul.sv
// Shared signed multiplier with cross-product operand selection and output register.
module rar_mul #(
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  rar_pkg::mul_ctl_t              ctl,
  input  logic signed [VALUE_BITS-1:0]   a_num,
  input  logic signed [VALUE_BITS-1:0]   a_den,
  input  logic signed [VALUE_BITS-1:0]   b_num,
  input  logic signed [VALUE_BITS-1:0]   b_den,
  output logic signed [2*VALUE_BITS-1:0] prod
);

  localparam int PW = 2 * VALUE_BITS;

  logic signed [VALUE_BITS-1:0] x;
  logic signed [VALUE_BITS-1:0] y;

  // add/sub/div: an*bd, ad*bn, ad*bd; mul: an*bn, ad*bd
  always_comb begin
    case (ctl.sel)
      rar_pkg::MS_FIRST: begin
        x = a_num;
        y = (ctl.op == rar_pkg::OP_MUL) ? b_num : b_den;
      end
      rar_pkg::MS_SECOND: begin
        x = a_den;
        y = (ctl.op == rar_pkg::OP_MUL) ? b_den : b_num;
      end
      default: begin
        x = a_den;
        y = b_den;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= PW'(x) * PW'(y);
    end
  end

endmodule

FILE: src/rar_reduce.sv
// Binary GCD followed by a two-lane restoring divide that reduces num/den.
module rar_reduce #(
  parameter int MAG_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MAG_BITS-1:0] num_mag,
  input  logic [MAG_BITS-1:0] den_mag,
  output logic                done,
  output logic [MAG_BITS-1:0] num_q,
  output logic [MAG_BITS-1:0] den_q
);

  localparam int MW = MAG_BITS;
  localparam int CW = $clog2(MW + 1);
  localparam logic [CW-1:0] LAST = CW'(MW - 1);

  rar_pkg::red_state_t state, state_next;

  logic [MW-1:0] u, v;
  logic [MW-1:0] ns, ds;
  logic [MW-1:0] rn, rd;
  logic [CW-1:0] cnt;

  logic          u_zero, u_ge_v;
  logic [MW-1:0] diff;
  logic [MW:0]   rn_sh, rd_sh, v_ext;
  logic          ge_n, ge_d;
  logic          div_last;

  assign u_zero   = (u == '0);
  assign u_ge_v   = (u >= v);
  assign diff     = u_ge_v ? (u - v) : (v - u);
  assign v_ext    = {1'b0, v};
  assign rn_sh    = {rn, ns[MW-1]};
  assign rd_sh    = {rd, ds[MW-1]};
  assign ge_n     = (rn_sh >= v_ext);
  assign ge_d     = (rd_sh >= v_ext);
  assign div_last = (cnt == LAST);

  assign num_q = ns;
  assign den_q = ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::RD_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == rar_pkg::RD_DIV) && div_last;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rar_pkg::RD_IDLE: if (start) state_next = rar_pkg::RD_GCD;
      rar_pkg::RD_GCD:  if (u_zero) state_next = rar_pkg::RD_DIV;
      rar_pkg::RD_DIV:  if (div_last) state_next = rar_pkg::RD_IDLE;
      default:          state_next = rar_pkg::RD_IDLE;
    endcase
  end

  // common factors of two come off ns/ds too, so the divisor left in v is odd
  always_ff @(posedge clk) begin
    case (state)
      rar_pkg::RD_IDLE: begin
        if (start) begin
          u  <= num_mag;
          v  <= den_mag;
          ns <= num_mag;
          ds <= den_mag;
        end
      end
      rar_pkg::RD_GCD: begin
        if (u_zero) begin
          cnt <= '0;
          rn  <= '0;
          rd  <= '0;
        end else if (!u[0] && !v[0]) begin
          u  <= u >> 1;
          v  <= v >> 1;
          ns <= ns >> 1;
          ds <= ds >> 1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u_ge_v) begin
          u <= diff >> 1;
        end else begin
          v <= diff >> 1;
        end
      end
      rar_pkg::RD_DIV: begin
        // quotient bits shift into the dividend registers
        ns  <= {ns[MW-2:0], ge_n};
        ds  <= {ds[MW-2:0], ge_d};
        rn  <= ge_n ? rn_sh[MW-1:0] - v : rn_sh[MW-1:0];
        rd  <= ge_d ? rd_sh[MW-1:0] - v : rd_sh[MW-1:0];
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/rational_arith_reduce_unit.sv
// Top level: sequencer over the shared multiplier and the GCD reduce unit.
// Sequence: accept, three multiplier steps, a wait for the last product, a zero check, then
// for a nonzero result the GCD loop and one divide step per quotient bit, then the output register.
// One item is in flight at a time; a zero result skips the GCD and divide loops.
// A new item is accepted once the previous result sits in the output register.
// Reset (synchronous, rst high) returns the sequencer to idle and clears the output valid.
module rational_arith_reduce_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rar_req_if.sink     req,
  rar_rsp_if.source   rsp
);

  localparam int PW = 2 * VALUE_BITS;
  localparam int SW = PW + 1;
  localparam int MW = PW;
  localparam int OW = (MW > rar_pkg::RES_NUM_W) ? MW : rar_pkg::RES_NUM_W;

  rar_pkg::state_t   state, state_next;
  rar_pkg::mul_ctl_t mul_ctl;

  rar_pkg::op_t                 op_r;
  logic signed [VALUE_BITS-1:0] a_num_r, a_den_r, b_num_r, b_den_r;
  logic signed [PW-1:0]         prod;
  logic [SW-1:0]                prod_ext;
  logic [SW-1:0]                num_raw, den_raw;
  logic [SW-1:0]                num_abs, den_abs;
  logic                         num_zero, den_zero;
  logic                         neg_r;
  logic                         red_start, red_done;
  logic [MW-1:0]                num_q, den_q;
  logic [OW-1:0]                nm_ext, dm_ext, sn;
  logic                         add_sub;

  logic signed [rar_pkg::RES_NUM_W-1:0] res_num_r, out_num;
  logic [rar_pkg::RES_DEN_W-1:0]        res_den_r, out_den;
  logic                                 status_r, out_status, out_valid;

  assign req.ready   = (state == rar_pkg::ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.res_num = out_num;
  assign rsp.res_den = out_den;
  assign rsp.status  = out_status;

  assign add_sub  = (op_r == rar_pkg::OP_ADD) || (op_r == rar_pkg::OP_SUB);
  assign prod_ext = {prod[PW-1], prod};
  assign num_abs  = num_raw[SW-1] ? (~num_raw + 1'b1) : num_raw;
  assign den_abs  = den_raw[SW-1] ? (~den_raw + 1'b1) : den_raw;
  assign num_zero = (num_raw == '0);
  assign den_zero = (den_raw == '0);
  assign nm_ext   = OW'(num_q);
  assign dm_ext   = OW'(den_q);
  assign sn       = neg_r ? (~nm_ext + 1'b1) : nm_ext;

  rar_mul #(.VALUE_BITS(VALUE_BITS)) u_mul (
    .clk   (clk),
    .ctl   (mul_ctl),
    .a_num (a_num_r),
    .a_den (a_den_r),
    .b_num (b_num_r),
    .b_den (b_den_r),
    .prod  (prod)
  );

  rar_reduce #(.MAG_BITS(MW)) u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .num_mag (num_abs[MW-1:0]),
    .den_mag (den_abs[MW-1:0]),
    .done    (red_done),
    .num_q   (num_q),
    .den_q   (den_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mul_ctl     = '0;
    mul_ctl.op  = op_r;
    red_start   = 1'b0;
    case (state)
      rar_pkg::ST_IDLE: if (req.valid) state_next = rar_pkg::ST_M0;
      rar_pkg::ST_M0: begin
        mul_ctl.en  = 1'b1;
        mul_ctl.sel = rar_pkg::MS_FIRST;
        state_next  = rar_pkg::ST_M1;
      end
      rar_pkg::ST_M1: begin
        mul_ctl.en  = 1'b1;
        mul_ctl.sel = rar_pkg::MS_SECOND;
        state_next  = rar_pkg::ST_M2;
      end
      rar_pkg::ST_M2: begin
        mul_ctl.en  = 1'b1;
        mul_ctl.sel = rar_pkg::MS_THIRD;
        state_next  = rar_pkg::ST_M3;
      end
      rar_pkg::ST_M3: state_next = rar_pkg::ST_CHECK;
      rar_pkg::ST_CHECK: begin
        if (den_zero || num_zero) begin
          state_next = rar_pkg::ST_OUT;
        end else begin
          red_start  = 1'b1;
          state_next = rar_pkg::ST_REDUCE;
        end
      end
      rar_pkg::ST_REDUCE: if (red_done) state_next = rar_pkg::ST_OUT;
      rar_pkg::ST_OUT: if (!out_valid || rsp.ready) state_next = rar_pkg::ST_IDLE;
      default: state_next = rar_pkg::ST_IDLE;
    endcase
  end

  // operand capture and raw numerator/denominator build-up
  always_ff @(posedge clk) begin
    case (state)
      rar_pkg::ST_IDLE: begin
        if (req.valid) begin
          op_r    <= rar_pkg::op_t'(req.req_type);
          a_num_r <= req.a_num;
          a_den_r <= req.a_den;
          b_num_r <= req.b_num;
          b_den_r <= req.b_den;
        end
      end
      rar_pkg::ST_M1: num_raw <= prod_ext;
      rar_pkg::ST_M2: begin
        if (op_r == rar_pkg::OP_ADD) begin
          num_raw <= num_raw + prod_ext;
        end else if (op_r == rar_pkg::OP_SUB) begin
          num_raw <= num_raw - prod_ext;
        end else begin
          den_raw <= prod_ext;
        end
      end
      rar_pkg::ST_M3: if (add_sub) den_raw <= prod_ext;
      rar_pkg::ST_CHECK: begin
        neg_r <= num_raw[SW-1] ^ den_raw[SW-1];
        if (den_zero) begin
          res_num_r <= '0;
          res_den_r <= '0;
          status_r  <= 1'b1;
        end else if (num_zero) begin
          res_num_r <= '0;
          res_den_r <= rar_pkg::RES_DEN_W'(1);
          status_r  <= 1'b0;
        end
      end
      rar_pkg::ST_REDUCE: begin
        if (red_done) begin
          res_num_r <= sn[rar_pkg::RES_NUM_W-1:0];
          res_den_r <= dm_ext[rar_pkg::RES_DEN_W-1:0];
          status_r  <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rar_pkg::ST_OUT && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rar_pkg::ST_OUT && (!out_valid || rsp.ready)) begin
      out_num    <= res_num_r;
      out_den    <= res_den_r;
      out_status <= status_r;
    end
  end

endmodule

FILE: src/rar_checker.sv
// Port-level assertions for the rational arithmetic reduce unit, with bind.
module rar_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [rar_pkg::RES_NUM_W-1:0] res_num,
  input logic [rar_pkg::RES_DEN_W-1:0]        res_den,
  input logic                                 status
);

  // one item at a time: an accept closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after an item was accepted");

  // a fresh result only appears as the sequencer returns to idle
  a_result_on_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while the unit was busy");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> res_num == '0 && res_den == '0)
    else $error("error result with nonzero fields");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(res_num) && $stable(res_den) && $stable(status))
    else $error("result payload changed while stalled");

endmodule

bind rational_arith_reduce_unit rar_checker u_rar_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .res_num   (rsp.res_num),
  .res_den   (rsp.res_den),
  .status    (rsp.status)
);

FILE: tb/rational_arith_reduce_unit_test.sv
// Self-checking testbench for the rational arithmetic reduce unit.
module rational_arith_reduce_unit_test;

  localparam int VALUE_BITS  = 16;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 250;
  localparam int RANDOM_ITEMS = 900;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  typedef struct {
    rar_pkg::op_t op;
    val_t an;
    val_t ad;
    val_t bn;
    val_t bd;
    bit   drain;  // hold this item back until all results are in
  } fraction_req_t;

  typedef struct {
    logic signed [rar_pkg::RES_NUM_W-1:0] num;
    logic [rar_pkg::RES_DEN_W-1:0]        den;
    logic                                 status;
  } fraction_res_t;

  logic clk;
  logic rst;

  rar_req_if #(.VALUE_BITS(VALUE_BITS)) req();
  rar_rsp_if rsp();

  rational_arith_reduce_unit #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  fraction_req_t pending_reqs[$];
  fraction_res_t reduced_results[$];
  int mismatches;
  int idle_cycles;

  // sender burst control
  int burst_left;
  int gap_left;

  // receiver stall pattern
  int stall_mode;
  int mode_left;
  int rsp_cycle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cross-multiply, then divide both parts by the gcd of their magnitudes.
  function automatic fraction_res_t reduce_fraction(fraction_req_t it);
    longint an, ad, bn, bd, num, den, x, y, t, nm, dm;
    bit neg;
    fraction_res_t r;
    an = it.an;
    ad = it.ad;
    bn = it.bn;
    bd = it.bd;
    case (it.op)
      rar_pkg::OP_ADD: begin
        num = an * bd + ad * bn;
        den = ad * bd;
      end
      rar_pkg::OP_SUB: begin
        num = an * bd - ad * bn;
        den = ad * bd;
      end
      rar_pkg::OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
      end
    endcase
    if (den == 0) begin
      r.num = '0;
      r.den = '0;
      r.status = 1'b1;
      return r;
    end
    x = (num < 0) ? -num : num;
    y = (den < 0) ? -den : den;
    nm = x;
    dm = y;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = nm / x;
    dm = dm / x;
    neg = ((num < 0) != (den < 0)) && (nm != 0);
    r.num = rar_pkg::RES_NUM_W'(neg ? -nm : nm);
    r.den = dm[rar_pkg::RES_DEN_W-1:0];
    r.status = 1'b0;
    return r;
  endfunction

  function automatic fraction_req_t make_req(rar_pkg::op_t op, int an, int ad, int bn, int bd);
    fraction_req_t it;
    it.op = op;
    it.an = val_t'(an);
    it.ad = val_t'(ad);
    it.bn = val_t'(bn);
    it.bd = val_t'(bd);
    it.drain = 1'b0;
    return it;
  endfunction

  // kind 0: any value, 1: small values so reduction does real work, 2: corner values
  function automatic val_t pick_value(int kind);
    int s;
    case (kind)
      0: s = int'($urandom_range(0, 65535));
      1: s = int'($urandom_range(0, 40)) - 20;
      default: begin
        case ($urandom_range(0, 6))
          0: s = -32768;
          1: s = 32767;
          2: s = 0;
          3: s = 1;
          4: s = -1;
          5: s = 1 << $urandom_range(0, 14);
          default: s = -(1 << $urandom_range(0, 14));
        endcase
      end
    endcase
    return val_t'(s);
  endfunction

  function automatic fraction_req_t random_req();
    fraction_req_t it;
    int style;
    int k;
    style = $urandom_range(0, 9);
    if (style < 4) k = 0;
    else if (style < 7) k = 1;
    else k = 2;
    it.op = rar_pkg::op_t'($urandom_range(0, 3));
    // mixed style draws each field from its own kind
    it.an = pick_value((style == 7 || style == 8) ? $urandom_range(0, 2) : k);
    it.ad = pick_value((style == 7 || style == 8) ? $urandom_range(0, 2) : k);
    it.bn = pick_value((style == 7 || style == 8) ? $urandom_range(0, 2) : k);
    it.bd = pick_value((style == 7 || style == 8) ? $urandom_range(0, 2) : k);
    it.drain = ($urandom_range(0, 149) == 0);
    return it;
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 10);
      2: return $urandom_range(10, 130);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic nxt_valid;
    if (rst) begin
      req.valid <= 1'b0;
      burst_left = $urandom_range(1, 10);
      gap_left = 0;
    end else begin
      nxt_valid = req.valid;
      if (req.valid && req.ready) begin
        reduced_results.push_back(reduce_fraction(pending_reqs.pop_front()));
        nxt_valid = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left = pick_gap();
        end
      end
      if (!nxt_valid && pending_reqs.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_reqs[0].drain && reduced_results.size() != 0)) begin
          nxt_valid = 1'b1;
          req.req_type <= pending_reqs[0].op;
          req.a_num <= pending_reqs[0].an;
          req.a_den <= pending_reqs[0].ad;
          req.b_num <= pending_reqs[0].bn;
          req.b_den <= pending_reqs[0].bd;
        end
      end
      req.valid <= nxt_valid;
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    fraction_res_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_mode = 0;
      mode_left = $urandom_range(100, 400);
      rsp_cycle = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (reduced_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0d/%0d status %0d",
                   $time, rsp.res_num, rsp.res_den, rsp.status);
          mismatches++;
        end else begin
          want = reduced_results.pop_front();
          check_field("res_num", want.num, rsp.res_num);
          check_field("res_den", want.den, rsp.res_den);
          check_field("status", want.status, rsp.status);
        end
      end
      rsp_cycle++;
      mode_left--;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(100, 600);
      end
      case (stall_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 1) == 1);
        2: rsp.ready <= ($urandom_range(0, 15) == 0);
        default: rsp.ready <= (rsp_cycle % 7) > 2;
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    fraction_req_t it;
    mismatches = 0;
    idle_cycles = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = '0;
    req.a_num = '0;
    req.a_den = '0;
    req.b_num = '0;
    req.b_den = '0;
    rsp.ready = 1'b0;

    pending_reqs.push_back(make_req(rar_pkg::OP_ADD, 1, 2, 1, 3));
    pending_reqs.push_back(make_req(rar_pkg::OP_SUB, 1, 2, 1, 2));
    pending_reqs.push_back(make_req(rar_pkg::OP_SUB, 1, 3, 1, 2));
    pending_reqs.push_back(make_req(rar_pkg::OP_MUL, -32768, -32768, -32768, -32768));
    pending_reqs.push_back(make_req(rar_pkg::OP_MUL, -32768, 1, -32768, 1));
    pending_reqs.push_back(make_req(rar_pkg::OP_DIV, 32767, -32768, -32768, 32767));
    pending_reqs.push_back(make_req(rar_pkg::OP_DIV, -32768, 32767, 32767, -32768));
    // zero result denominator
    pending_reqs.push_back(make_req(rar_pkg::OP_ADD, 5, 0, 3, 7));
    pending_reqs.push_back(make_req(rar_pkg::OP_SUB, 5, 9, 3, 0));
    pending_reqs.push_back(make_req(rar_pkg::OP_MUL, 4, 3, 2, 0));
    pending_reqs.push_back(make_req(rar_pkg::OP_DIV, 4, 3, 0, 5));
    pending_reqs.push_back(make_req(rar_pkg::OP_DIV, 0, 0, 0, 0));
    // divide by a fraction with zero denominator: numerator vanishes, no error
    pending_reqs.push_back(make_req(rar_pkg::OP_DIV, 7, 3, 5, 0));
    pending_reqs.push_back(make_req(rar_pkg::OP_MUL, 0, 5, 7, 3));
    pending_reqs.push_back(make_req(rar_pkg::OP_ADD, -32768, -32768, -32768, -32768));
    pending_reqs.push_back(make_req(rar_pkg::OP_SUB, 32767, 1, -32768, 1));
    pending_reqs.push_back(make_req(rar_pkg::OP_SUB, -32768, 1, 32767, -1));
    pending_reqs.push_back(make_req(rar_pkg::OP_ADD, 32767, 32766, 32767, -32765));
    pending_reqs.push_back(make_req(rar_pkg::OP_MUL, 6, -4, 10, 15));
    pending_reqs.push_back(make_req(rar_pkg::OP_DIV, -3, 4, -9, 8));
    pending_reqs.push_back(make_req(rar_pkg::OP_DIV, 32767, 32767, 1, -1));
    pending_reqs.push_back(make_req(rar_pkg::OP_MUL, -1, -1, -1, -1));
    pending_reqs.push_back(make_req(rar_pkg::OP_ADD, 32767, 32767, 32767, 32767));
    pending_reqs.push_back(make_req(rar_pkg::OP_ADD, -32768, 32767, 32767, -32768));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      it = random_req();
      if (i == 0) it.drain = 1'b1;
      pending_reqs.push_back(it);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0) @(posedge clk);
    while (reduced_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
